>>> rtl/segment_rect_edge_intersect_defines.svh
// Assertion macros shared by the segment/rectangle edge test RTL.
`ifndef SEGMENT_RECT_EDGE_INTERSECT_DEFINES_SVH
`define SEGMENT_RECT_EDGE_INTERSECT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during rst
`define SRE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication, sampled on clk, off during rst
`define SRE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define SRE_ASSERT_IMPL(label, ante, cons)
`define SRE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/sre_pkg.sv
// Shared widths, word types and stage payloads for the segment/rectangle edge test.
package sre_pkg;

  localparam int COORD_BITS = 24;
  localparam int SIZE_BITS  = COORD_BITS - 1;
  // offset of an edge start from the segment origin
  localparam int VW = COORD_BITS + 2;
  // size times direction
  localparam int DW = 2 * COORD_BITS;
  // offset times direction or size
  localparam int PW = COORD_BITS + VW;
  // numerator after the cross-product subtract
  localparam int NW = PW + 1;

  localparam int EDGES       = 4;
  localparam int EDGE_TOP    = 0;
  localparam int EDGE_RIGHT  = 1;
  localparam int EDGE_BOTTOM = 2;
  localparam int EDGE_LEFT   = 3;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ray_origin_x;
    logic signed [COORD_BITS-1:0] ray_origin_y;
    logic signed [COORD_BITS-1:0] ray_dir_x;
    logic signed [COORD_BITS-1:0] ray_dir_y;
    logic signed [COORD_BITS-1:0] rect_x;
    logic signed [COORD_BITS-1:0] rect_y;
    logic        [SIZE_BITS-1:0]  rect_w;
    logic        [SIZE_BITS-1:0]  rect_h;
  } req_t;

  typedef struct packed {
    logic                hit;
    logic [EDGES-1:0]    edge_mask;
  } rsp_t;

  // offsets of the near and far corners from the origin
  typedef struct packed {
    logic signed [VW-1:0]         vx0;
    logic signed [VW-1:0]         vx1;
    logic signed [VW-1:0]         vy0;
    logic signed [VW-1:0]         vy1;
    logic signed [COORD_BITS-1:0] dx;
    logic signed [COORD_BITS-1:0] dy;
    logic        [SIZE_BITS-1:0]  w;
    logic        [SIZE_BITS-1:0]  h;
  } diff_t;

  // all products needed by the top, right, bottom and left edges
  typedef struct packed {
    logic signed [DW-1:0] den_w;
    logic signed [DW-1:0] den_h;
    logic signed [PW-1:0] pxy0;
    logic signed [PW-1:0] pxy1;
    logic signed [PW-1:0] pyx0;
    logic signed [PW-1:0] pyx1;
    logic signed [PW-1:0] qw0;
    logic signed [PW-1:0] qw1;
    logic signed [PW-1:0] qh0;
    logic signed [PW-1:0] qh1;
  } prod_t;

  // per-edge numerators and denominator
  typedef struct packed {
    logic signed [NW-1:0] n1;
    logic signed [NW-1:0] n2;
    logic signed [NW-1:0] den;
  } edge_num_t;

endpackage

>>> rtl/segment_rect_edge_intersect.sv
// Top level: pipelined segment versus axis-aligned rectangle edge crossing test.
// Takes one word per cycle while req_stall is low. Each accepted word moves in order
// through four register stages to the outputs. The four register stages are: corner
// offsets, the ten signed products (the widest logic, which sets the clock), the edge
// numerator subtract, and the sign-aware range compares that form the edge mask.
// Each stage moves on its own when the next one is empty or moving, so bubbles close
// up and input is held off only when all four stages are full and the output stalls.
`include "segment_rect_edge_intersect_defines.svh"

module segment_rect_edge_intersect (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  sre_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sre_pkg::rsp_t rsp
);

  logic [3:0]     vld;
  logic [3:0]     rdy;
  sre_pkg::diff_t diff;
  sre_pkg::prod_t prod;

  // per-stage room: empty, or the next stage moves
  assign rdy[3] = !vld[3] || !rsp_stall;
  assign rdy[2] = !vld[2] || rdy[3];
  assign rdy[1] = !vld[1] || rdy[2];
  assign rdy[0] = !vld[0] || rdy[1];

  assign req_stall = !rdy[0];
  assign rsp_valid = vld[3];

  sre_diff u_diff (
    .clk       (clk),
    .rst       (rst),
    .ready     (rdy[0]),
    .req_valid (req_valid),
    .req       (req),
    .valid     (vld[0]),
    .diff      (diff)
  );

  sre_mul u_mul (
    .clk      (clk),
    .rst      (rst),
    .ready    (rdy[1]),
    .in_valid (vld[0]),
    .diff     (diff),
    .valid    (vld[1]),
    .prod     (prod)
  );

  sre_test u_test (
    .clk      (clk),
    .rst      (rst),
    .ready    (rdy[3:2]),
    .in_valid (vld[1]),
    .prod     (prod),
    .valid    (vld[3:2]),
    .rsp      (rsp)
  );

  // input is held off only with a full pipe and a stalled output
  `SRE_ASSERT_IMPL(a_stall_only_full, req_stall, (&vld) && rsp_stall)
  // a stalled numerator stage keeps its word
  `SRE_ASSERT_NEXT(a_num_holds, vld[2] && !rdy[2], vld[2])
  // hit agrees with the edge mask
  `SRE_ASSERT_IMPL(a_hit_mask, rsp_valid, rsp.hit == (rsp.edge_mask != '0))

endmodule

>>> rtl/sre_diff.sv
// First stage: corner offsets from the segment origin.
module sre_diff (
  input  logic          clk,
  input  logic          rst,
  input  logic          ready,
  input  logic          req_valid,
  input  sre_pkg::req_t req,
  output logic          valid,
  output sre_pkg::diff_t diff
);

  logic signed [sre_pkg::VW-1:0] ox, oy, cx, cy, wv, hv;
  sre_pkg::diff_t diff_next;

  // widen coordinates; sizes are zero-extended
  assign ox = sre_pkg::VW'(req.ray_origin_x);
  assign oy = sre_pkg::VW'(req.ray_origin_y);
  assign cx = sre_pkg::VW'(req.rect_x);
  assign cy = sre_pkg::VW'(req.rect_y);
  assign wv = $signed(sre_pkg::VW'(req.rect_w));
  assign hv = $signed(sre_pkg::VW'(req.rect_h));

  // offsets of both x and both y edge lines
  always_comb begin
    diff_next.vx0 = cx - ox;
    diff_next.vx1 = cx + wv - ox;
    diff_next.vy0 = cy - oy;
    diff_next.vy1 = cy + hv - oy;
    diff_next.dx  = req.ray_dir_x;
    diff_next.dy  = req.ray_dir_y;
    diff_next.w   = req.rect_w;
    diff_next.h   = req.rect_h;
  end

  // advance the stage when downstream has room
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && req_valid) begin
      diff <= diff_next;
    end
  end

endmodule

>>> rtl/sre_mul.sv
// Second stage: the ten signed products of the edge cross products.
module sre_mul (
  input  logic           clk,
  input  logic           rst,
  input  logic           ready,
  input  logic           in_valid,
  input  sre_pkg::diff_t diff,
  output logic           valid,
  output sre_pkg::prod_t prod
);

  logic signed [sre_pkg::COORD_BITS-1:0] ws, hs;
  sre_pkg::prod_t prod_next;

  assign ws = $signed({1'b0, diff.w});
  assign hs = $signed({1'b0, diff.h});

  // form every product once; the edges share them
  always_comb begin
    prod_next.den_w = sre_pkg::DW'(ws) * sre_pkg::DW'(diff.dy);
    prod_next.den_h = sre_pkg::DW'(hs) * sre_pkg::DW'(diff.dx);
    prod_next.pxy0  = sre_pkg::PW'(diff.vx0) * sre_pkg::PW'(diff.dy);
    prod_next.pxy1  = sre_pkg::PW'(diff.vx1) * sre_pkg::PW'(diff.dy);
    prod_next.pyx0  = sre_pkg::PW'(diff.dx) * sre_pkg::PW'(diff.vy0);
    prod_next.pyx1  = sre_pkg::PW'(diff.dx) * sre_pkg::PW'(diff.vy1);
    prod_next.qw0   = sre_pkg::PW'(ws) * sre_pkg::PW'(diff.vy0);
    prod_next.qw1   = sre_pkg::PW'(ws) * sre_pkg::PW'(diff.vy1);
    prod_next.qh0   = sre_pkg::PW'(hs) * sre_pkg::PW'(diff.vx0);
    prod_next.qh1   = sre_pkg::PW'(hs) * sre_pkg::PW'(diff.vx1);
  end

  // advance the stage when downstream has room
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      prod <= prod_next;
    end
  end

endmodule

>>> rtl/sre_test.sv
// Third and fourth stages: edge numerators, then range compares into the result word.
module sre_test (
  input  logic           clk,
  input  logic           rst,
  input  logic [1:0]     ready,
  input  logic           in_valid,
  input  sre_pkg::prod_t prod,
  output logic [1:0]     valid,
  output sre_pkg::rsp_t  rsp
);

  sre_pkg::edge_num_t [sre_pkg::EDGES-1:0] num_next, num;
  logic [sre_pkg::EDGES-1:0] mask_next;

  // n/den lies in (0,1], judged without division
  function automatic logic in_unit(input logic signed [sre_pkg::NW-1:0] n,
                                   input logic signed [sre_pkg::NW-1:0] den);
    logic den_pos, den_neg;
    den_pos = !den[sre_pkg::NW-1] && (den != '0);
    den_neg = den[sre_pkg::NW-1];
    return (den_pos && !n[sre_pkg::NW-1] && (n != '0) && (n <= den)) ||
           (den_neg && n[sre_pkg::NW-1] && (n >= den));
  endfunction

  // edge numerators; top and left carry both signs flipped, which keeps the ratios
  always_comb begin
    num_next[sre_pkg::EDGE_TOP].n1     = sre_pkg::NW'(prod.pyx0) - sre_pkg::NW'(prod.pxy0);
    num_next[sre_pkg::EDGE_TOP].n2     = sre_pkg::NW'(prod.qw0);
    num_next[sre_pkg::EDGE_TOP].den    = sre_pkg::NW'(prod.den_w);
    num_next[sre_pkg::EDGE_RIGHT].n1   = sre_pkg::NW'(prod.pxy1) - sre_pkg::NW'(prod.pyx0);
    num_next[sre_pkg::EDGE_RIGHT].n2   = sre_pkg::NW'(prod.qh1);
    num_next[sre_pkg::EDGE_RIGHT].den  = sre_pkg::NW'(prod.den_h);
    num_next[sre_pkg::EDGE_BOTTOM].n1  = sre_pkg::NW'(prod.pxy1) - sre_pkg::NW'(prod.pyx1);
    num_next[sre_pkg::EDGE_BOTTOM].n2  = sre_pkg::NW'(prod.qw1);
    num_next[sre_pkg::EDGE_BOTTOM].den = sre_pkg::NW'(prod.den_w);
    num_next[sre_pkg::EDGE_LEFT].n1    = sre_pkg::NW'(prod.pyx1) - sre_pkg::NW'(prod.pxy0);
    num_next[sre_pkg::EDGE_LEFT].n2    = sre_pkg::NW'(prod.qh0);
    num_next[sre_pkg::EDGE_LEFT].den   = sre_pkg::NW'(prod.den_h);
  end

  // both parameters in range on each edge
  always_comb begin
    for (int e = 0; e < sre_pkg::EDGES; e++) begin
      mask_next[e] = in_unit(num[e].n1, num[e].den) && in_unit(num[e].n2, num[e].den);
    end
  end

  // advance each stage when the next has room
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 2'b00;
    end else begin
      if (ready[0]) begin
        valid[0] <= in_valid;
      end
      if (ready[1]) begin
        valid[1] <= valid[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready[0] && in_valid) begin
      num <= num_next;
    end
    if (ready[1] && valid[0]) begin
      rsp.hit       <= |mask_next;
      rsp.edge_mask <= mask_next;
    end
  end

endmodule

>>> sim/testbench.sv
// Testbench for segment_rect_edge_intersect: random and directed words vs. a predictor.
module testbench;

  localparam int ONE        = 256;       // 1.0 in Q15.8
  localparam int MINC       = -8388608;
  localparam int MAXC       = 8388607;
  localparam int MAXS       = 8388607;
  localparam int CYCLE_CAP  = 400000;
  localparam int TAIL_WAIT  = 16;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  sre_pkg::req_t  req = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  sre_pkg::rsp_t  rsp;

  sre_pkg::rsp_t  expected_masks[$];
  int    mismatch_count = 0;
  int    cycle_count = 0;
  int    send_idle_pct = 0;
  int    rsp_stall_pct = 0;

  segment_rect_edge_intersect dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Decide one edge: both cross-product ratios must lie in (0,1], no division.
  function automatic bit edge_crossed(longint ox, longint oy, longint dx, longint dy,
                                      longint px, longint py, longint lx, longint ly);
    longint den, vx, vy, n_seg, n_edge;
    den = dx * ly - lx * dy;
    if (den == 0) return 1'b0;
    vx = px - ox;
    vy = py - oy;
    n_seg  = vx * dy - dx * vy;
    n_edge = vx * ly - lx * vy;
    if (den > 0) return n_seg > 0 && n_seg <= den && n_edge > 0 && n_edge <= den;
    return n_seg < 0 && n_seg >= den && n_edge < 0 && n_edge >= den;
  endfunction

  // Build the top, right, bottom and left edges in order and collect the crossing mask.
  function automatic sre_pkg::rsp_t predict_crossings(sre_pkg::req_t w);
    longint ox, oy, dx, dy, cx, cy, sw, sh;
    sre_pkg::rsp_t r;
    ox = w.ray_origin_x;
    oy = w.ray_origin_y;
    dx = w.ray_dir_x;
    dy = w.ray_dir_y;
    cx = w.rect_x;
    cy = w.rect_y;
    sw = w.rect_w;
    sh = w.rect_h;
    r.edge_mask = '0;
    r.edge_mask[sre_pkg::EDGE_TOP]    = edge_crossed(ox, oy, dx, dy, cx, cy, sw, 0);
    r.edge_mask[sre_pkg::EDGE_RIGHT]  = edge_crossed(ox, oy, dx, dy, cx + sw, cy, 0, sh);
    r.edge_mask[sre_pkg::EDGE_BOTTOM] = edge_crossed(ox, oy, dx, dy, cx + sw, cy + sh,
                                                     -sw, 0);
    r.edge_mask[sre_pkg::EDGE_LEFT]   = edge_crossed(ox, oy, dx, dy, cx, cy + sh, 0, -sh);
    r.hit = |r.edge_mask;
    return r;
  endfunction

  function automatic sre_pkg::req_t make_word(int ox, int oy, int dx, int dy,
                                              int cx, int cy, int w, int h);
    sre_pkg::req_t r;
    r.ray_origin_x = sre_pkg::COORD_BITS'(ox);
    r.ray_origin_y = sre_pkg::COORD_BITS'(oy);
    r.ray_dir_x    = sre_pkg::COORD_BITS'(dx);
    r.ray_dir_y    = sre_pkg::COORD_BITS'(dy);
    r.rect_x       = sre_pkg::COORD_BITS'(cx);
    r.rect_y       = sre_pkg::COORD_BITS'(cy);
    r.rect_w       = sre_pkg::SIZE_BITS'(w);
    r.rect_h       = sre_pkg::SIZE_BITS'(h);
    return r;
  endfunction

  // Favor the extremes, otherwise any value.
  function automatic logic [sre_pkg::COORD_BITS-1:0] pick_coord();
    case ($urandom_range(7))
      0:       return {1'b1, {(sre_pkg::COORD_BITS-1){1'b0}}};
      1:       return {1'b0, {(sre_pkg::COORD_BITS-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return sre_pkg::COORD_BITS'($urandom);
    endcase
  endfunction

  // Segment between two points near a rectangle, often snapped onto an edge or corner.
  function automatic sre_pkg::req_t aimed_segment();
    int sz, w, h, cx, cy, mw, mh, x0, y0, x1, y1;
    sz = $urandom_range(14, 2);
    if ($urandom_range(15) == 0) sz = 21;
    w  = $urandom_range(1 << sz, 0);
    h  = $urandom_range(1 << sz, 0);
    if ($urandom_range(15) == 0) w = 0;
    if ($urandom_range(15) == 0) h = 0;
    cx = int'($urandom_range(1 << 22, 0)) - (1 << 21);
    cy = int'($urandom_range(1 << 22, 0)) - (1 << 21);
    mw = w / 2 + ONE;
    mh = h / 2 + ONE;
    x0 = cx - mw + int'($urandom_range(w + 2 * mw, 0));
    y0 = cy - mh + int'($urandom_range(h + 2 * mh, 0));
    x1 = cx - mw + int'($urandom_range(w + 2 * mw, 0));
    y1 = cy - mh + int'($urandom_range(h + 2 * mh, 0));
    case ($urandom_range(11))
      0: x1 = cx;
      1: x1 = cx + w;
      2: y1 = cy;
      3: y1 = cy + h;
      4: x0 = cx + w;
      5: y0 = cy;
      6: y1 = y0;
      7: begin
        x1 = cx;
        y1 = cy + h;
      end
      8: x1 = x0;
      default: ;
    endcase
    return make_word(x0, y0, x1 - x0, y1 - y0, cx, cy, w, h);
  endfunction

  // Offer one word, hold it until taken, then queue its expected result.
  task automatic send_word(input sre_pkg::req_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (req_stall);
    expected_masks.push_back(predict_crossings(w));
  endtask

  task automatic stop_sending();
    @(negedge clk);
    req_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_masks.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct = send_pct;
    rsp_stall_pct = stall_pct;
  endtask

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endtask

  // Field extremes, parallel edges, endpoint touches and corners past the field range.
  task automatic test_directed();
    // straight through left and right, top and bottom, then diagonally through left and right
    send_word(make_word(-5*ONE, 5*ONE, 20*ONE, 0, 0, 0, 10*ONE, 10*ONE));
    send_word(make_word(5*ONE, -5*ONE, 0, 20*ONE, 0, 0, 10*ONE, 10*ONE));
    send_word(make_word(-5*ONE, -3*ONE, 20*ONE, 16*ONE, 0, 0, 10*ONE, 10*ONE));
    // fully inside, no crossing
    send_word(make_word(2*ONE, 2*ONE, 3*ONE, 3*ONE, 0, 0, 10*ONE, 10*ONE));
    // zero-length segment and zero-size rectangles
    send_word(make_word(0, 5*ONE, 0, 0, 0, 0, 10*ONE, 10*ONE));
    send_word(make_word(-ONE, -ONE, 2*ONE, 2*ONE, 0, 0, 0, 0));
    send_word(make_word(-5*ONE, 5*ONE, 10*ONE, 0, 0, 0, 0, 10*ONE));
    // collinear with the top edge
    send_word(make_word(-5*ONE, 0, 20*ONE, 0, 0, 0, 10*ONE, 10*ONE));
    // segment ends on the left edge, starts on it going out, starts on it going in
    send_word(make_word(-5*ONE, 5*ONE, 5*ONE, 0, 0, 0, 10*ONE, 10*ONE));
    send_word(make_word(0, 5*ONE, -5*ONE, 0, 0, 0, 10*ONE, 10*ONE));
    send_word(make_word(0, 5*ONE, 5*ONE, 0, 0, 0, 10*ONE, 10*ONE));
    // ends on a corner, passes through two corners
    send_word(make_word(-5*ONE, -5*ONE, 5*ONE, 5*ONE, 0, 0, 10*ONE, 10*ONE));
    send_word(make_word(-5*ONE, -5*ONE, 20*ONE, 20*ONE, 0, 0, 10*ONE, 10*ONE));
    // smallest steps
    send_word(make_word(-1, 1, 2, 0, 0, 0, 2, 2));
    send_word(make_word(1, -1, 0, 1, 0, 0, 2, 1));
    // extremes of every field
    send_word(make_word(MINC, MINC, MAXC, MAXC, MINC, MINC, MAXS, MAXS));
    send_word(make_word(MAXC, MAXC, MINC, MINC, MAXC, MAXC, MAXS, MAXS));
    send_word(make_word(MINC, 0, MAXC, 0, -ONE, MINC, MAXS, MAXS));
    send_word(make_word(0, MINC, 0, MAXC, MINC, -ONE, MAXS, MAXS));
    // right or bottom edge beyond the coordinate range, or the left edge, reached exactly at the segment end
    send_word(make_word(MAXC, 2*ONE, MAXC, 0, MAXC, 0, MAXS, 4*ONE));
    send_word(make_word(0, 2*ONE, MAXC, 0, MAXC, 0, MAXS, 4*ONE));
    send_word(make_word(2*ONE, MAXC, 0, MAXC, 0, MAXC, 4*ONE, MAXS));
    stop_sending();
  endtask

  // Hold off the sender until every pending result is back.
  task automatic test_drain_pause();
    repeat (8) send_word(aimed_segment());
    stop_sending();
    wait_drained();
    repeat (8) send_word(aimed_segment());
    stop_sending();
  endtask

  task automatic test_aimed_segments(input int n);
    repeat (n) send_word(aimed_segment());
    stop_sending();
  endtask

  task automatic test_full_range(input int n);
    sre_pkg::req_t w;
    repeat (n) begin
      w.ray_origin_x = pick_coord();
      w.ray_origin_y = pick_coord();
      w.ray_dir_x    = pick_coord();
      w.ray_dir_y    = pick_coord();
      w.rect_x       = pick_coord();
      w.rect_y       = pick_coord();
      w.rect_w       = sre_pkg::SIZE_BITS'(pick_coord());
      w.rect_h       = sre_pkg::SIZE_BITS'(pick_coord());
      send_word(w);
    end
    stop_sending();
  endtask

  // Randomly stall the result side.
  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
  end

  // Count cycles and compare each taken result word with the oldest expectation.
  always @(posedge clk) begin : check_results
    sre_pkg::rsp_t want;
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("testbench: FAIL");
      $finish;
    end else if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_masks.size() == 0) begin
        log_mismatch($sformatf("unexpected word hit=%0b mask=%b", rsp.hit, rsp.edge_mask));
      end else begin
        want = expected_masks.pop_front();
        if (rsp.hit !== want.hit)
          log_mismatch($sformatf("hit expected %0b got %0b", want.hit, rsp.hit));
        if (rsp.edge_mask !== want.edge_mask)
          log_mismatch($sformatf("edge_mask expected %b got %b",
                                 want.edge_mask, rsp.edge_mask));
      end
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_drain_pause();

    set_idling(0, 0);
    test_aimed_segments(220);
    test_full_range(90);

    set_idling(55, 0);
    test_aimed_segments(220);
    test_full_range(90);

    set_idling(0, 55);
    test_aimed_segments(220);
    test_full_range(90);

    set_idling(33, 33);
    test_aimed_segments(220);
    test_full_range(90);

    // drain, then watch for stray words
    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatch_count == 0 && expected_masks.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
